// ----- design/sorted_deadline_timer_queue_defines.svh -----
// Assertion macros shared by the timer queue modules.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define SDTQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SDTQ_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- design/sdtq_pkg.sv -----
package sdtq_pkg;
   localparam int DEPTH_DEFAULT = 32;
   localparam int TIME_BITS_DEFAULT = 32;
   localparam int HANDLE_BITS = 5;
   localparam int OP_BITS = 2;
   localparam int KIND_BITS = 3;
   localparam int DL_OUT_BITS = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_ADJUST = 2'd1,
      OP_DELETE = 2'd2,
      OP_TICK = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_EXPIRED = 3'd0,
      KIND_DONE = 3'd1,
      KIND_NONE = 3'd2,
      KIND_FULL = 3'd3,
      KIND_UNKNOWN = 3'd4,
      KIND_DUP = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_INSERT,
      ST_POP,
      ST_OUT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic remove;
      logic insert;
      logic pop;
      logic set_rsp;
      logic rsp_last;
      kind_type rsp_kind;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic found;
      logic full;
      logic empty;
      logic head_due;
   } status_type;
endpackage

// ----- design/sdtq_ctrl.sv -----
`include "sorted_deadline_timer_queue_defines.svh"
module sdtq_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  sdtq_pkg::op_type op_ff,
   input  sdtq_pkg::status_type status,
   output sdtq_pkg::cmd_type cmd
);
   sdtq_pkg::state_type state_ff, state_in;
   logic popped_ff, popped_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdtq_pkg::ST_IDLE;
         popped_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         popped_ff <= popped_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      popped_in = popped_ff;
      unique case (state_ff)
         sdtq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sdtq_pkg::ST_DECIDE;
               popped_in = 1'b0;
            end
         end
         sdtq_pkg::ST_DECIDE: begin
            if (op_ff == sdtq_pkg::OP_TICK) begin
               state_in = sdtq_pkg::ST_POP;
            end else if (op_ff == sdtq_pkg::OP_ADJUST && status.found) begin
               state_in = sdtq_pkg::ST_INSERT;
            end else begin
               state_in = sdtq_pkg::ST_OUT;
            end
         end
         sdtq_pkg::ST_INSERT: state_in = sdtq_pkg::ST_OUT;
         sdtq_pkg::ST_POP: begin
            if (!status.empty && status.head_due) begin
               state_in = sdtq_pkg::ST_OUT;
               popped_in = 1'b1;
            end else if (!popped_ff) begin
               state_in = sdtq_pkg::ST_OUT;
            end else begin
               state_in = sdtq_pkg::ST_IDLE;
            end
         end
         sdtq_pkg::ST_OUT: begin
            if (rsp_ready) begin
               state_in = (op_ff == sdtq_pkg::OP_TICK && popped_ff) ?
                  sdtq_pkg::ST_POP : sdtq_pkg::ST_IDLE;
            end
         end
         default: state_in = sdtq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rsp_kind = sdtq_pkg::KIND_DONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         sdtq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         sdtq_pkg::ST_DECIDE: begin
            unique case (op_ff)
               sdtq_pkg::OP_TICK: ;
               sdtq_pkg::OP_ADD: begin
                  cmd.set_rsp = 1'b1;
                  cmd.rsp_last = 1'b1;
                  if (status.found) begin
                     cmd.rsp_kind = sdtq_pkg::KIND_DUP;
                  end else if (status.full) begin
                     cmd.rsp_kind = sdtq_pkg::KIND_FULL;
                  end else begin
                     cmd.insert = 1'b1;
                  end
               end
               default: begin
                  cmd.set_rsp = 1'b1;
                  cmd.rsp_last = 1'b1;
                  if (status.found) begin
                     cmd.remove = 1'b1;
                  end else begin
                     cmd.rsp_kind = sdtq_pkg::KIND_UNKNOWN;
                  end
               end
            endcase
         end
         sdtq_pkg::ST_INSERT: cmd.insert = 1'b1;
         sdtq_pkg::ST_POP: begin
            if (!status.empty && status.head_due) begin
               cmd.pop = 1'b1;
               cmd.set_rsp = 1'b1;
               cmd.rsp_kind = sdtq_pkg::KIND_EXPIRED;
            end else if (!popped_ff) begin
               cmd.set_rsp = 1'b1;
               cmd.rsp_last = 1'b1;
               cmd.rsp_kind = sdtq_pkg::KIND_NONE;
            end
         end
         sdtq_pkg::ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   `SDTQ_ASSERT(a_one_side, clock, reset, !(req_ready && rsp_valid), "ready while result pending")
   `SDTQ_ASSERT(a_load_idle, clock, reset, cmd.load |-> state_ff == sdtq_pkg::ST_IDLE, "load out of idle")
   `SDTQ_ASSERT(a_pop_head, clock, reset, cmd.pop |-> !status.empty, "pop of empty queue")
endmodule

// ----- design/sdtq_datapath.sv -----
`include "sorted_deadline_timer_queue_defines.svh"
module sdtq_datapath #(
   parameter int DEPTH = sdtq_pkg::DEPTH_DEFAULT,
   parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic [sdtq_pkg::OP_BITS-1:0] req_op,
   input  logic [sdtq_pkg::HANDLE_BITS-1:0] req_handle,
   input  logic [31:0] req_deadline,
   input  logic [31:0] req_now,
   input  sdtq_pkg::cmd_type cmd,
   output sdtq_pkg::status_type status,
   output sdtq_pkg::op_type op_ff,
   output logic [sdtq_pkg::KIND_BITS-1:0] rsp_kind,
   output logic [sdtq_pkg::HANDLE_BITS-1:0] rsp_expired_handle,
   output logic [sdtq_pkg::DL_OUT_BITS-1:0] rsp_expired_deadline,
   output logic rsp_last
);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int TB = (TIME_BITS < 32) ? TIME_BITS : 32;

   // Shift chain: slot 0 is the earliest deadline.
   logic [TIME_BITS-1:0] dl_ff [DEPTH];
   logic [TIME_BITS-1:0] dl_in [DEPTH];
   logic [sdtq_pkg::HANDLE_BITS-1:0] hd_ff [DEPTH];
   logic [sdtq_pkg::HANDLE_BITS-1:0] hd_in [DEPTH];
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [sdtq_pkg::HANDLE_BITS-1:0] handle_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic [DEPTH-1:0] live, match, after;
   logic [sdtq_pkg::KIND_BITS-1:0] kind_ff;
   logic [sdtq_pkg::HANDLE_BITS-1:0] rh_ff;
   logic [sdtq_pkg::DL_OUT_BITS-1:0] rd_ff;
   logic last_ff;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         live[i] = CNT_BITS'(i) < count_ff;
         match[i] = live[i] && hd_ff[i] == handle_ff;
         after[i] = !live[i] || dl_ff[i] > time_ff;
      end
   end

   // Slots at or above the found match, for removal.
   logic [DEPTH-1:0] at_or_above;
   always_comb begin
      at_or_above[0] = match[0];
      for (int i = 1; i < DEPTH; i++) at_or_above[i] = at_or_above[i-1] | match[i];
   end

   assign status.found = |match;
   assign status.full = count_ff == CNT_BITS'(DEPTH);
   assign status.empty = count_ff == '0;
   assign status.head_due = dl_ff[0] <= time_ff;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         dl_in[i] = dl_ff[i];
         hd_in[i] = hd_ff[i];
      end
      count_in = count_ff;
      if (cmd.remove || cmd.pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (cmd.pop || at_or_above[i]) begin
               dl_in[i] = dl_ff[i+1];
               hd_in[i] = hd_ff[i+1];
            end
         end
         count_in = count_ff - 1'b1;
      end else if (cmd.insert) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (after[i]) begin
               if (i == 0 || after[i-1 < 0 ? 0 : i-1] == 1'b1 && i != 0) begin
                  dl_in[i] = (i == 0) ? time_ff : dl_ff[i-1 < 0 ? 0 : i-1];
                  hd_in[i] = (i == 0) ? handle_ff : hd_ff[i-1 < 0 ? 0 : i-1];
               end else begin
                  dl_in[i] = time_ff;
                  hd_in[i] = handle_ff;
               end
            end
         end
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         dl_ff[i] <= dl_in[i];
         hd_ff[i] <= hd_in[i];
      end
      if (cmd.load) begin
         op_ff <= sdtq_pkg::op_type'(req_op);
         handle_ff <= req_handle;
         time_ff <= (req_op == sdtq_pkg::OP_TICK) ? TIME_BITS'(req_now[TB-1:0])
                                                   : TIME_BITS'(req_deadline[TB-1:0]);
      end
      if (cmd.set_rsp) begin
         kind_ff <= cmd.rsp_kind;
         last_ff <= cmd.rsp_last;
         if (cmd.rsp_kind == sdtq_pkg::KIND_EXPIRED) begin
            rh_ff <= hd_ff[0];
            rd_ff <= sdtq_pkg::DL_OUT_BITS'(dl_ff[0]);
         end else begin
            rh_ff <= (cmd.rsp_kind == sdtq_pkg::KIND_NONE) ? '0 : handle_ff;
            rd_ff <= '0;
         end
      end
   end

   // The final pop of a tick is marked once the next head is known.
   always_comb begin
      rsp_kind = kind_ff;
      rsp_expired_handle = rh_ff;
      rsp_expired_deadline = rd_ff;
      rsp_last = last_ff || (kind_ff == sdtq_pkg::KIND_EXPIRED && (status.empty || !status.head_due));
   end

   `SDTQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_BITS'(DEPTH), "count overflow")
   `SDTQ_ASSERT(a_no_full_insert, clock, reset, cmd.insert |-> !status.full, "insert into full queue")
   `SDTQ_ASSERT(a_head_order, clock, reset, count_ff > 1 |-> dl_ff[0] <= dl_ff[1], "head out of order")
endmodule

// ----- design/sorted_deadline_timer_queue.sv -----
// Channel   Ports                                          Direction
// request   req_valid/req_ready, op, handle, deadline, now  in
// response  rsp_valid/rsp_ready, kind, expired_handle,      out
//           expired_deadline, last
// Add, delete and a rejected request pass through the decide and output states;
// adjust also passes through the insert state before its result.
// A tick returns one result per popped timer, as the shift chain pops a single entry
// on each pass through the pop state, or one none result when nothing is due. Reset is
// synchronous and empties the queue.
// A stalled result holds the controller; no new request is taken until the
// last result of the current one transfers.
module sorted_deadline_timer_queue #(
   parameter int DEPTH = sdtq_pkg::DEPTH_DEFAULT,
   parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [sdtq_pkg::OP_BITS-1:0] req_op,
   input  logic [sdtq_pkg::HANDLE_BITS-1:0] req_handle,
   input  logic [31:0] req_deadline,
   input  logic [31:0] req_now,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [sdtq_pkg::KIND_BITS-1:0] rsp_kind,
   output logic [sdtq_pkg::HANDLE_BITS-1:0] rsp_expired_handle,
   output logic [sdtq_pkg::DL_OUT_BITS-1:0] rsp_expired_deadline,
   output logic rsp_last
);
   sdtq_pkg::cmd_type cmd;
   sdtq_pkg::status_type status;
   sdtq_pkg::op_type op_ff;

   sdtq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .op_ff(op_ff),
      .status(status), .cmd(cmd)
   );

   sdtq_datapath #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
      .clock(clock), .reset(reset), .req_op(req_op), .req_handle(req_handle),
      .req_deadline(req_deadline), .req_now(req_now), .cmd(cmd), .status(status),
      .op_ff(op_ff), .rsp_kind(rsp_kind), .rsp_expired_handle(rsp_expired_handle),
      .rsp_expired_deadline(rsp_expired_deadline), .rsp_last(rsp_last)
   );
endmodule
